FILE: design/mcsp_pkg.sv
// Shared types and constants for the mesh chunk stream parser.
package mcsp_pkg;

    localparam int unsigned NAME_LIMIT_DEF = 20;

    localparam logic [15:0] ID_MAIN    = 16'h4d4d;
    localparam logic [15:0] ID_EDIT    = 16'h3d3d;
    localparam logic [15:0] ID_OBJECT  = 16'h4000;
    localparam logic [15:0] ID_TRIMESH = 16'h4100;
    localparam logic [15:0] ID_VERTS   = 16'h4110;
    localparam logic [15:0] ID_FACES   = 16'h4120;
    localparam logic [15:0] ID_MAPS    = 16'h4140;

    localparam logic [31:0] HDR_LEN = 32'd6;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_VERTEX = 3'd2;
    localparam logic [2:0] KIND_FACE   = 3'd3;
    localparam logic [2:0] KIND_MAP    = 3'd4;
    localparam logic [2:0] KIND_SHORT  = 3'd5;

    typedef struct packed {
        logic [2:0]  rec_kind;
        logic [15:0] chunk_code;
        logic [31:0] chunk_size;
        logic [15:0] item_index;
        logic [15:0] list_count;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic        last_in_list;
    } rec_t;

endpackage

FILE: design/mcsp_if.sv
// Channel interfaces: file bytes in, parsed records out.
interface mcsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface mcsp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  rec_kind;
    logic [15:0] chunk_code;
    logic [31:0] chunk_size;
    logic [15:0] item_index;
    logic [15:0] list_count;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic        last_in_list;

    modport source (output valid, input ready, output rec_kind, output chunk_code,
                    output chunk_size, output item_index, output list_count,
                    output word_a, output word_b, output word_c, output last_in_list);
    modport sink   (input valid, output ready, input rec_kind, input chunk_code,
                    input chunk_size, input item_index, input list_count,
                    input word_a, input word_b, input word_c, input last_in_list);
endinterface

FILE: design/mesh_chunk_stream_parser.sv
// Byte-serial 3DS chunk parser: one file byte per item in, decoded records out.
//
// stream carries one file byte per item; first_byte high restarts the parser
// and that same byte is the first byte of a chunk header. records carries at
// most one record per byte: a chunk header on the sixth header byte, a name
// character, a vertex, face or mapping element on the last byte of that
// element, or a short-length error.
// A byte that completes a record is registered into the output register, or
// into the skid entry when the output stalls. One byte is accepted every cycle
// while the skid entry is empty; parse state updates in one registered step.
// Records go through a two-entry output buffer (output register plus skid
// entry), so a byte is still taken in the cycle the receiver first stalls;
// stream.ready drops only while the skid entry is occupied.
// Reset clears the parse state to header reading and empties the buffer.
// There is no end-of-file marker: an unfinished chunk continues with the next
// bytes unless first_byte restarts the parse.
module mesh_chunk_stream_parser #(
    parameter int unsigned NAME_LIMIT = mcsp_pkg::NAME_LIMIT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mcsp_byte_if.sink   stream,
    mcsp_rec_if.source  records
);
    import mcsp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_COUNT,
        PH_VERT,
        PH_FACE,
        PH_MAP,
        PH_SKIP
    } phase_t;

    localparam logic [16:0] NAME_LIM = 17'(NAME_LIMIT);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bpos_reg, bpos_next;
    logic [31:0] asm_reg [3];
    logic [31:0] asm_next [3];
    logic [15:0] code_reg, code_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] lpos_reg, lpos_next;
    logic [31:0] skip_reg, skip_next;

    rec_t        main_reg, skid_reg, res;
    logic        main_valid_reg, skid_valid_reg;
    logic        res_fire;

    // working copies of the state after an optional restart
    phase_t      ph;
    logic [3:0]  bp;
    logic [31:0] aw [3];
    logic [15:0] code;
    logic [31:0] size;
    logic [15:0] total;
    logic [15:0] lpos;
    logic [31:0] skip;

    logic [7:0]  d;
    logic        acc, pop;
    logic        wr_en;
    logic [1:0]  widx;
    logic [4:0]  wsh;
    logic [3:0]  elen;
    logic [2:0]  ekind;
    logic [1:0]  hlane;

    assign d            = stream.data_byte;
    assign stream.ready = !skid_valid_reg;
    assign acc          = stream.valid && stream.ready;
    assign pop          = main_valid_reg && records.ready;

    always_comb
    begin
        ph    = phase_reg;
        bp    = bpos_reg;
        aw    = asm_reg;
        code  = code_reg;
        size  = size_reg;
        total = total_reg;
        lpos  = lpos_reg;
        skip  = skip_reg;
        if (stream.first_byte)
        begin
            ph    = PH_HEADER;
            bp    = '0;
            aw    = '{default: '0};
            code  = '0;
            size  = '0;
            total = '0;
            lpos  = '0;
            skip  = '0;
        end

        phase_next = ph;
        bpos_next  = bp;
        asm_next   = aw;
        code_next  = code;
        size_next  = size;
        total_next = total;
        lpos_next  = lpos;
        skip_next  = skip;

        res_fire = 1'b0;
        res      = '0;
        wr_en    = 1'b0;
        widx     = '0;
        wsh      = '0;
        elen     = 4'd8;
        ekind    = KIND_MAP;
        hlane    = 2'(bp - 4'd2);

        case (ph)
            PH_HEADER:
            begin
                case (bp)
                    4'd0:    code_next = {8'b0, d};
                    4'd1:    code_next = code | {d, 8'b0};
                    4'd2:    size_next = {24'b0, d};
                    default: size_next = size | ({24'b0, d} << {hlane, 3'b000});
                endcase
                if (bp == 4'd5)
                begin
                    bpos_next   = '0;
                    res_fire    = 1'b1;
                    res.rec_kind = KIND_HEADER;
                    if (code_next inside {ID_MAIN, ID_EDIT, ID_TRIMESH})
                        phase_next = PH_HEADER;
                    else if (code_next == ID_OBJECT)
                    begin
                        phase_next = PH_NAME;
                        lpos_next  = '0;
                    end
                    else if (code_next inside {ID_VERTS, ID_FACES, ID_MAPS})
                    begin
                        phase_next = PH_COUNT;
                        total_next = '0;
                    end
                    else if (size_next < HDR_LEN)
                    begin
                        phase_next   = PH_HEADER;
                        res.rec_kind = KIND_SHORT;
                    end
                    else
                    begin
                        skip_next  = size_next - HDR_LEN;
                        phase_next = (skip_next != '0) ? PH_SKIP : PH_HEADER;
                    end
                end
                else
                    bpos_next = bp + 4'd1;
            end

            PH_NAME:
            begin
                res_fire          = 1'b1;
                res.rec_kind      = KIND_NAME;
                res.item_index    = lpos;
                res.word_a        = {24'b0, d};
                res.last_in_list  = (d == 8'd0) || ({1'b0, lpos} + 17'd1 >= NAME_LIM);
                if (res.last_in_list)
                    phase_next = PH_HEADER;
                else
                    lpos_next = lpos + 16'd1;
            end

            PH_COUNT:
            begin
                if (bp == 4'd0)
                begin
                    total_next = {8'b0, d};
                    bpos_next  = 4'd1;
                end
                else
                begin
                    total_next = total | {d, 8'b0};
                    bpos_next  = '0;
                    lpos_next  = '0;
                    asm_next   = '{default: '0};
                    if (total_next == '0)
                        phase_next = PH_HEADER;
                    else if (code == ID_VERTS)
                        phase_next = PH_VERT;
                    else if (code == ID_FACES)
                        phase_next = PH_FACE;
                    else
                        phase_next = PH_MAP;
                end
            end

            PH_VERT, PH_FACE, PH_MAP:
            begin
                if (ph == PH_FACE)
                begin
                    // three 16-bit indices, then the flags word is dropped
                    ekind = KIND_FACE;
                    wr_en = bp < 4'd6;
                    widx  = bp[2:1];
                    wsh   = {1'b0, bp[0], 3'b000};
                end
                else if (ph == PH_VERT)
                begin
                    elen  = 4'd12;
                    ekind = KIND_VERTEX;
                    wr_en = bp < 4'd12;
                    widx  = bp[3:2];
                    wsh   = {bp[1:0], 3'b000};
                end
                else
                begin
                    wr_en = bp < 4'd8;
                    widx  = {1'b0, bp[2]};
                    wsh   = {bp[1:0], 3'b000};
                end
                for (int w = 0; w < 3; w++)
                begin
                    if (wr_en && widx == 2'(w))
                        asm_next[w] = aw[w] | ({24'b0, d} << wsh);
                end
                bpos_next = bp + 4'd1;
                if (bpos_next == elen)
                begin
                    res_fire         = 1'b1;
                    res.rec_kind     = ekind;
                    res.item_index   = lpos;
                    res.list_count   = total;
                    res.word_a       = asm_next[0];
                    res.word_b       = asm_next[1];
                    res.word_c       = asm_next[2];
                    res.last_in_list = ({1'b0, lpos} + 17'd1) == {1'b0, total};
                    asm_next         = '{default: '0};
                    bpos_next        = '0;
                    lpos_next        = lpos + 16'd1;
                    if (lpos_next == total)
                        phase_next = PH_HEADER;
                end
            end

            PH_SKIP:
            begin
                if (skip != '0)
                    skip_next = skip - 32'd1;
                if (skip_next == '0)
                    phase_next = PH_HEADER;
            end

            default:
            begin
                phase_next = PH_HEADER;
                bpos_next  = '0;
            end
        endcase

        res.chunk_code = code_next;
        res.chunk_size = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            bpos_reg       <= '0;
            asm_reg        <= '{default: '0};
            code_reg       <= '0;
            size_reg       <= '0;
            total_reg      <= '0;
            lpos_reg       <= '0;
            skip_reg       <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            main_reg       <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg <= phase_next;
                bpos_reg  <= bpos_next;
                asm_reg   <= asm_next;
                code_reg  <= code_next;
                size_reg  <= size_next;
                total_reg <= total_next;
                lpos_reg  <= lpos_next;
                skip_reg  <= skip_next;
            end

            // two-entry output buffer; the skid entry only fills under a stall
            if (!main_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    main_reg       <= skid_reg;
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_reg       <= res;
                    main_valid_reg <= acc && res_fire;
                end
            end
            else if (acc && res_fire)
            begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign records.valid        = main_valid_reg;
    assign records.rec_kind     = main_reg.rec_kind;
    assign records.chunk_code   = main_reg.chunk_code;
    assign records.chunk_size   = main_reg.chunk_size;
    assign records.item_index   = main_reg.item_index;
    assign records.list_count   = main_reg.list_count;
    assign records.word_a       = main_reg.word_a;
    assign records.word_b       = main_reg.word_b;
    assign records.word_c       = main_reg.word_c;
    assign records.last_in_list = main_reg.last_in_list;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !records.ready))
        else $error("skid entry filled without a stalled output");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_bpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER && bpos_reg < 4'd6) ||
        (phase_reg == PH_COUNT && bpos_reg < 4'd2) ||
        (phase_reg == PH_VERT && bpos_reg < 4'd12) ||
        ((phase_reg == PH_FACE || phase_reg == PH_MAP) && bpos_reg < 4'd8) ||
        phase_reg == PH_NAME || phase_reg == PH_SKIP)
        else $error("byte position out of range for the parse phase");

    a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VERT || phase_reg == PH_FACE || phase_reg == PH_MAP)
            |-> lpos_reg < total_reg)
        else $error("list position past the declared count");

endmodule

FILE: verif/mesh_chunk_stream_parser_tb.sv
// Testbench for mesh_chunk_stream_parser: directed table, then random mesh files vs predictor.
module mesh_chunk_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsp_pkg::*;

    typedef enum logic [2:0] {
        ST_HDR,
        ST_NAME,
        ST_COUNT,
        ST_VERT,
        ST_FACE,
        ST_MAP,
        ST_SKIP
    } parse_st_t;

    // One file byte; when fixed is set the record it completes is given inline
    // (kind, code and size, all other fields zero).
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        fixed;
        logic [2:0]  kind;
        logic [15:0] code;
        logic [31:0] size;
    } byte_row_t;

    localparam int N_DIR = 28;
    localparam int N_RAND = 1850;
    localparam int N_CALM = 250;
    localparam int LONG_HOLD = 400;

    // kind/code/size matter only on fixed rows
    localparam byte_row_t DIR_ROWS [N_DIR] = '{
        // unknown id, length 5: short-length error instead of a header record
        '{8'hff, 1'b1, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h05, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b1, KIND_SHORT,  16'hffff, 32'h0000_0005},
        // object chunk with all-ones length, one name char, then restart
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h40, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'hff, 1'b0, 1'b1, KIND_HEADER, ID_OBJECT, 32'hffff_ffff},
        '{8'h41, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        // restart mid-name: face list with zero length field, then empty count
        '{8'h20, 1'b1, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h41, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b1, KIND_HEADER, ID_FACES, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        // unknown chunk of length 7: one byte skipped
        '{8'h34, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h12, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h07, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b1, KIND_HEADER, 16'h1234, 32'h0000_0007},
        '{8'hff, 1'b0, 1'b0, KIND_HEADER, 16'h0000, 32'h0000_0000}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcsp_byte_if byte_ch ();
    mcsp_rec_if  rec_ch ();

    mesh_chunk_stream_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_ch),
        .records (rec_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser state mirror
    parse_st_t   phase;
    logic [3:0]  byte_pos;
    logic [31:0] elem_words [3];
    logic [15:0] cur_code;
    logic [31:0] cur_size;
    logic [15:0] elem_total;
    logic [15:0] elem_pos;
    logic [31:0] skip_left;

    rec_t        pending_recs [$];
    byte_row_t   rand_rows [$];
    logic [7:0]  file_buf [$];

    int  n_fail = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_in_stall = 0;
    int  kind_seen [6];
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    bit  calm = 1'b0;
    bit  squeezed = 1'b0;

    function automatic void clear_parse();
        phase = ST_HDR;
        byte_pos = '0;
        elem_words = '{default: '0};
        cur_code = '0;
        cur_size = '0;
        elem_total = '0;
        elem_pos = '0;
        skip_left = '0;
    endfunction

    function automatic rec_t make_rec(input logic [2:0] kind, input logic [15:0] idx,
                                      input logic [15:0] cnt, input logic [31:0] a,
                                      input logic [31:0] b, input logic [31:0] c,
                                      input logic fin);
        rec_t r;
        r.rec_kind = kind;
        r.chunk_code = cur_code;
        r.chunk_size = cur_size;
        r.item_index = idx;
        r.list_count = cnt;
        r.word_a = a;
        r.word_b = b;
        r.word_c = c;
        r.last_in_list = fin;
        return r;
    endfunction

    // Advance the mirror by one file byte; returns 1 when a record is due.
    function automatic bit parse_byte(input logic [7:0] d, input logic restart,
                                      output rec_t r);
        int unsigned elen;
        logic [2:0]  kind;
        logic        fin;
        r = '0;
        if (restart)
            clear_parse();
        case (phase)
            ST_HDR:
            begin
                case (byte_pos)
                    4'd0: cur_code = {8'h00, d};
                    4'd1: cur_code[15:8] = d;
                    4'd2: cur_size = {24'h0, d};
                    default: cur_size = cur_size | (32'(d) << (8 * (byte_pos - 4'd2)));
                endcase
                byte_pos = byte_pos + 4'd1;
                if (byte_pos < 4'd6)
                    return 1'b0;
                byte_pos = '0;
                kind = KIND_HEADER;
                case (cur_code)
                    ID_MAIN, ID_EDIT, ID_TRIMESH:
                        phase = ST_HDR;
                    ID_OBJECT:
                    begin
                        phase = ST_NAME;
                        elem_pos = '0;
                    end
                    ID_VERTS, ID_FACES, ID_MAPS:
                    begin
                        phase = ST_COUNT;
                        elem_total = '0;
                    end
                    default:
                    begin
                        if (cur_size < HDR_LEN)
                        begin
                            phase = ST_HDR;
                            kind = KIND_SHORT;
                        end
                        else
                        begin
                            skip_left = cur_size - HDR_LEN;
                            phase = (skip_left != 0) ? ST_SKIP : ST_HDR;
                        end
                    end
                endcase
                r = make_rec(kind, '0, '0, '0, '0, '0, 1'b0);
                return 1'b1;
            end
            ST_NAME:
            begin
                fin = (d == 8'h00) || (32'(elem_pos) + 1 >= NAME_LIMIT_DEF);
                r = make_rec(KIND_NAME, elem_pos, '0, 32'(d), '0, '0, fin);
                if (fin)
                    phase = ST_HDR;
                else
                    elem_pos = elem_pos + 16'd1;
                return 1'b1;
            end
            ST_COUNT:
            begin
                if (byte_pos == 4'd0)
                begin
                    elem_total = {8'h00, d};
                    byte_pos = 4'd1;
                    return 1'b0;
                end
                elem_total[15:8] = d;
                byte_pos = '0;
                elem_pos = '0;
                elem_words = '{default: '0};
                if (elem_total == 16'd0)
                    phase = ST_HDR;
                else if (cur_code == ID_VERTS)
                    phase = ST_VERT;
                else if (cur_code == ID_FACES)
                    phase = ST_FACE;
                else
                    phase = ST_MAP;
                return 1'b0;
            end
            ST_VERT, ST_FACE, ST_MAP:
            begin
                if (phase == ST_FACE)
                begin
                    elen = 8;
                    kind = KIND_FACE;
                    // 16-bit indices in the first six bytes; the flags word is dropped
                    if (byte_pos < 4'd6)
                        elem_words[byte_pos >> 1] |= 32'(d) << (byte_pos[0] ? 8 : 0);
                end
                else
                begin
                    elen = (phase == ST_VERT) ? 12 : 8;
                    kind = (phase == ST_VERT) ? KIND_VERTEX : KIND_MAP;
                    elem_words[(byte_pos >> 2) % 3] |= 32'(d) << (8 * byte_pos[1:0]);
                end
                byte_pos = byte_pos + 4'd1;
                if (byte_pos < elen)
                    return 1'b0;
                fin = (32'(elem_pos) + 1 == 32'(elem_total));
                r = make_rec(kind, elem_pos, elem_total, elem_words[0], elem_words[1],
                             elem_words[2], fin);
                elem_words = '{default: '0};
                byte_pos = '0;
                elem_pos = elem_pos + 16'd1;
                if (elem_pos == elem_total)
                    phase = ST_HDR;
                return 1'b1;
            end
            ST_SKIP:
            begin
                if (skip_left > 0)
                    skip_left = skip_left - 1;
                if (skip_left == 0)
                    phase = ST_HDR;
                return 1'b0;
            end
            default:
            begin
                phase = ST_HDR;
                byte_pos = '0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(3))
            0: return 0;
            1: return 3;
            2: return 10;
            default: return 30;
        endcase
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        file_buf = {file_buf, b};
    endfunction

    function automatic void put_le(input logic [31:0] v, input int nb);
        for (int i = 0; i < nb; i++)
            append_byte(v[8 * i +: 8]);
    endfunction

    // Appends one random chunk, mostly well formed, to file_buf.
    function automatic void add_chunk();
        int          pick;
        int          n;
        int          len;
        logic [15:0] code;
        logic [31:0] size;
        pick = $urandom_range(99);
        size = $urandom;
        if (pick < 12)
        begin
            case ($urandom_range(2))
                0: code = ID_MAIN;
                1: code = ID_EDIT;
                default: code = ID_TRIMESH;
            endcase
            put_le(code, 2);
            put_le(size, 4);
        end
        else if (pick < 27)
        begin
            put_le(ID_OBJECT, 2);
            put_le(size, 4);
            // long names run into the limit with no terminator
            n = $urandom_range(24);
            for (int i = 0; i < n && i < NAME_LIMIT_DEF; i++)
                append_byte(8'($urandom_range(255, 1)));
            if (n < NAME_LIMIT_DEF)
                append_byte(8'h00);
        end
        else if (pick < 77)
        begin
            if (pick < 47)
            begin
                code = ID_VERTS;
                len = 12;
            end
            else if (pick < 62)
            begin
                code = ID_FACES;
                len = 8;
            end
            else
            begin
                code = ID_MAPS;
                len = 8;
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(5);
            put_le(code, 2);
            put_le(size, 4);
            put_le(n, 2);
            repeat (n * len) append_byte(8'($urandom));
        end
        else if (pick < 95)
        begin
            do
                code = 16'($urandom);
            while (code inside {ID_MAIN, ID_EDIT, ID_OBJECT, ID_TRIMESH, ID_VERTS, ID_FACES,
                                ID_MAPS});
            size = ($urandom_range(3) == 0) ? $urandom_range(5) : $urandom_range(30, 6);
            put_le(code, 2);
            put_le(size, 4);
            if (size >= HDR_LEN)
                repeat (size - HDR_LEN) append_byte(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(4, 1)) append_byte(8'($urandom));
        end
    endfunction

    function automatic void add_file();
        int        keep;
        byte_row_t row;
        file_buf.delete();
        if ($urandom_range(9) < 6)
        begin
            put_le(ID_MAIN, 2);
            put_le($urandom, 4);
        end
        repeat ($urandom_range(12, 1)) add_chunk();
        keep = file_buf.size();
        // some files are cut short; the next file's first byte restarts the parse
        if ($urandom_range(9) == 0)
            keep = $urandom_range(file_buf.size(), 1);
        for (int i = 0; i < keep && rand_rows.size() < N_RAND - N_DIR; i++)
        begin
            row = '0;
            row.data = file_buf[i];
            row.first = (i == 0);
            rand_rows = {rand_rows, row};
        end
    endfunction

    task automatic send_byte(input byte_row_t row);
        rec_t r;
        bit   got;
        if (!calm && $urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= row.data;
        byte_ch.first_byte <= row.first;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        got = parse_byte(row.data, row.first, r);
        if (row.fixed)
        begin
            r = '0;
            r.rec_kind = row.kind;
            r.chunk_code = row.code;
            r.chunk_size = row.size;
            got = 1'b1;
        end
        if (got)
            pending_recs = {pending_recs, r};
        n_sent++;
        @(negedge clk);
    endtask

    function automatic void check_field(input string tag, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want)
        begin
            n_fail++;
            if (n_fail <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, seen);
        end
    endfunction

    always @(posedge clk)
    begin : rec_check
        rec_t want;
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            if (pending_recs.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 40)
                    $display("%0t: unexpected record, expected none, actual kind %0d code %0h",
                             $time, rec_ch.rec_kind, rec_ch.chunk_code);
            end
            else
            begin
                want = pending_recs.pop_front();
                check_field("rec_kind", 32'(want.rec_kind), 32'(rec_ch.rec_kind));
                check_field("chunk_code", 32'(want.chunk_code), 32'(rec_ch.chunk_code));
                check_field("chunk_size", want.chunk_size, rec_ch.chunk_size);
                check_field("item_index", 32'(want.item_index), 32'(rec_ch.item_index));
                check_field("list_count", 32'(want.list_count), 32'(rec_ch.list_count));
                check_field("word_a", want.word_a, rec_ch.word_a);
                check_field("word_b", want.word_b, rec_ch.word_b);
                check_field("word_c", want.word_c, rec_ch.word_c);
                check_field("last_in_list", 32'(want.last_in_list), 32'(rec_ch.last_in_list));
                if (want.rec_kind <= KIND_SHORT)
                    kind_seen[want.rec_kind]++;
                n_checked++;
            end
        end
        if (rst_n && byte_ch.valid && !byte_ch.ready)
            n_in_stall++;
    end

    // receiver: random stall bursts, one long hold-off to back up the input
    initial
    begin : sink_side
        int hold;
        rec_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && !squeezed && n_checked >= 150)
            begin
                squeezed = 1'b1;
                rec_ch.ready <= 1'b0;
                hold = LONG_HOLD;
            end
            else if (!calm && $urandom_range(99) < sink_idle_pct)
            begin
                rec_ch.ready <= 1'b0;
                hold = $urandom_range(16, 1);
            end
            else
            begin
                rec_ch.ready <= 1'b1;
                hold = $urandom_range(8, 1);
            end
            repeat (hold) @(negedge clk);
            if ($urandom_range(31) == 0)
                sink_idle_pct = pick_idle();
        end
    end

    initial
    begin : run
        int guard;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.first_byte = 1'b0;
        clear_parse();
        while (rand_rows.size() < N_RAND - N_DIR)
            add_file();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_byte(DIR_ROWS[i]);

        foreach (rand_rows[i])
        begin
            if (i % 100 == 0)
                src_idle_pct = pick_idle();
            if (i + N_CALM >= rand_rows.size())
                calm = 1'b1;
            send_byte(rand_rows[i]);
        end
        byte_ch.valid <= 1'b0;

        guard = 0;
        while (pending_recs.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_recs.size() != 0)
        begin
            n_fail += pending_recs.size();
            $display("%0t: %0d expected records never arrived", $time, pending_recs.size());
        end

        $display("Drove %0d file bytes (%0d directed), checked %0d records, input stalled %0d cycles",
                 n_sent, N_DIR, n_checked, n_in_stall);
        $display("Records: %0d headers, %0d name chars, %0d vertices, %0d faces, %0d map, %0d short",
                 kind_seen[KIND_HEADER], kind_seen[KIND_NAME], kind_seen[KIND_VERTEX],
                 kind_seen[KIND_FACE], kind_seen[KIND_MAP], kind_seen[KIND_SHORT]);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
